// ----- rtl/pmnc_pkg.sv -----
// Package for the palette merge block: request and outcome codes, widths.
// No dependencies.
package pmnc_pkg;
    localparam int Entries = 256;
    localparam int IdxW = 8;
    localparam int DistW = 18;
    localparam logic [DistW-1:0] DistStart = 18'h2FFFF;
    localparam logic [7:0] ApproxFlag = 8'h10;

    typedef enum logic [1:0] {
        REQ_MERGE = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        OUT_UNTOUCHED = 3'd0,
        OUT_OWN       = 3'd1,
        OUT_SAME      = 3'd2,
        OUT_EXACT     = 3'd3,
        OUT_FREE      = 3'd4,
        OUT_APPROX    = 3'd5,
        OUT_ACCESS    = 3'd6
    } t_outcome;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] index;
        logic [7:0] used;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       force_req;
    } t_req_item;

    typedef struct packed {
        logic [7:0] mapped_index;
        logic [2:0] outcome;
        logic [7:0] entry_used;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
    } t_res_item;
endpackage

// ----- rtl/pmnc_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on pmnc_pkg.
interface pmnc_req_if;
    logic                  valid;
    logic                  ready;
    pmnc_pkg::t_req_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pmnc_res_if;
    logic                  valid;
    logic                  ready;
    pmnc_pkg::t_res_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pmnc_dist.sv -----
// Squared-distance unit: two register stages, one entry per cycle.
// Depends on pmnc_pkg.
module pmnc_dist (
    input  logic                 i_clk,
    input  logic [7:0]           i_ra,
    input  logic [7:0]           i_ga,
    input  logic [7:0]           i_ba,
    input  logic [7:0]           i_rb,
    input  logic [7:0]           i_gb,
    input  logic [7:0]           i_bb,
    output logic [pmnc_pkg::DistW-1:0] o_dist
);
    import pmnc_pkg::*;
    logic [7:0] n_dr, n_dg, n_db;
    logic [7:0] r_dr, r_dg, r_db;
    logic [15:0] sq_r, sq_g, sq_b;
    logic [DistW-1:0] r_dist;

    // absolute differences, then squares of the held differences
    always_comb begin
        n_dr = (i_ra > i_rb) ? i_ra - i_rb : i_rb - i_ra;
        n_dg = (i_ga > i_gb) ? i_ga - i_gb : i_gb - i_ga;
        n_db = (i_ba > i_bb) ? i_ba - i_bb : i_bb - i_ba;
        sq_r = {8'h00, r_dr} * {8'h00, r_dr};
        sq_g = {8'h00, r_dg} * {8'h00, r_dg};
        sq_b = {8'h00, r_db} * {8'h00, r_db};
    end

    always_ff @(posedge i_clk) begin
        r_dr <= n_dr;
        r_dg <= n_dg;
        r_db <= n_db;
        r_dist <= DistW'(sq_r) + DistW'(sq_g) + DistW'(sq_b);
    end

    assign o_dist = r_dist;
endmodule

// ----- rtl/palette_merge_nearest_color.sv -----
// Top level of the palette merge block: sequencer and palette memory.
// Depends on pmnc_pkg, pmnc_if and pmnc_dist.
//
// Requests arrive on i_req (valid/ready), one result per request leaves on
// o_res. A transfer on i_req starts one request; ready stays low until its
// result has been taken.
// After reset a clearing pass writes all 256 palette entries, one a cycle;
// no request is taken meanwhile. Entry 0 comes out used, entry 255 used and
// white.
// A read passes S_RD, S_DEC and S_OUT before the next ready; a write also
// passes S_FREEW. A merge that must search scans entries 1..254 through the
// distance unit, one entry per cycle, drains its 3-stage pipeline and,
// unless an exact match was found, scans 1..255 for a free slot; with
// none free it takes the approximate path.
// The single-port palette memory read sets the pace of both scans.
// The result is held in an output register while the receiver stalls;
// the sequencer waits in its output state until the transfer happens.
module palette_merge_nearest_color (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pmnc_req_if.sink     i_req,
    pmnc_res_if.source   o_res
);
    import pmnc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_DEC, S_SCAN, S_DRAIN, S_FREE, S_FREEW,
        S_APRD, S_APWR, S_OUT
    } t_state;

    logic [31:0] r_mem [Entries];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [IdxW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    t_state r_state;
    t_req_item r_item;
    t_res_item r_res;
    logic [IdxW:0] r_cnt;      // scan address, wide enough for end test
    logic [IdxW-1:0] r_p1, r_p2, r_p3; // address delayed with memory and dist unit
    logic r_v1, r_v2, r_v3;    // scan slot valid, then qualified by entry used, delayed likewise
    logic [IdxW-1:0] r_best;
    logic [DistW-1:0] r_bestd;
    logic r_found;
    logic [DistW-1:0] sq_dist;
    t_res_item dec_res;
    t_state dec_state;

    function automatic t_res_item merge_res(logic [IdxW-1:0] k, t_outcome oc);
        t_res_item res;
        res = '0;
        res.mapped_index = k;
        res.outcome = oc;
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_rdata <= r_mem[mem_addr];
    end

    pmnc_dist u_dist (
        .i_clk(i_clk),
        .i_ra(r_rdata[23:16]), .i_ga(r_rdata[15:8]), .i_ba(r_rdata[7:0]),
        .i_rb(r_item.red), .i_gb(r_item.green), .i_bb(r_item.blue),
        .o_dist(sq_dist)
    );

    wire [31:0] item_word = {r_item.used, r_item.red, r_item.green, r_item.blue};

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_addr = r_item.index;
        mem_wdata = item_word;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_addr = r_cnt[IdxW-1:0];
                mem_wdata = (r_cnt[IdxW-1:0] == '0) ? 32'h0100_0000 :
                            (r_cnt[IdxW-1:0] == IdxW'(Entries-1)) ? 32'h01FF_FFFF : '0;
            end
            S_IDLE: mem_addr = i_req.data.index;
            S_SCAN, S_FREE: mem_addr = r_cnt[IdxW-1:0];
            // store the request colour: direct write, own slot or free slot
            S_FREEW: begin
                mem_we = 1'b1;
                mem_addr = r_best;
            end
            S_APRD: mem_addr = r_best;
            S_APWR: begin
                mem_we = 1'b1;
                mem_addr = r_best;
                mem_wdata = r_rdata | {ApproxFlag, 24'h0};
            end
            default: ;
        endcase
    end

    // decode a request once its own palette entry has been read
    always_comb begin
        dec_res = merge_res(r_item.index, OUT_UNTOUCHED);
        dec_state = S_OUT;
        unique case (t_req'(r_item.req_type))
            REQ_WRITE: begin
                dec_res.outcome = OUT_ACCESS;
                dec_state = S_FREEW;
            end
            REQ_READ: begin
                dec_res.outcome = OUT_ACCESS;
                dec_res.entry_used = r_rdata[31:24];
                dec_res.entry_red = r_rdata[23:16];
                dec_res.entry_green = r_rdata[15:8];
                dec_res.entry_blue = r_rdata[7:0];
            end
            REQ_MERGE: begin
                if (r_item.index == '0 || r_item.index == IdxW'(Entries-1) ||
                    r_item.used == '0) begin
                    dec_res.outcome = OUT_UNTOUCHED;
                end else if (r_item.force_req || r_rdata[31:24] == '0 ||
                             r_item.used[1]) begin
                    dec_res.outcome = OUT_OWN;
                    dec_state = S_FREEW;
                end else if (r_rdata[23:0] == item_word[23:0]) begin
                    dec_res.outcome = OUT_SAME;
                end else begin
                    dec_state = S_SCAN;
                end
            end
            REQ_NONE: dec_res.outcome = OUT_UNTOUCHED;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_OUT);
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (IdxW+1)'(Entries-1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_req.valid) begin
                    r_item <= i_req.data;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_DEC; // memory read in flight
                S_DEC: begin
                    r_res <= dec_res;
                    r_best <= (dec_state == S_FREEW) ? r_item.index : IdxW'(Entries-1);
                    r_bestd <= DistStart;
                    r_found <= 1'b0;
                    r_cnt <= (IdxW+1)'(1);
                    r_v1 <= 1'b0;
                    r_v2 <= 1'b0;
                    r_v3 <= 1'b0;
                    r_state <= dec_state;
                end
                S_SCAN, S_DRAIN: begin
                    // pipeline: address -> rdata -> differences -> distance
                    r_p1 <= r_cnt[IdxW-1:0];
                    r_v1 <= (r_state == S_SCAN);
                    r_p2 <= r_p1;
                    r_v2 <= r_v1 && (r_rdata[31:24] != '0);
                    r_p3 <= r_p2;
                    r_v3 <= r_v2;
                    if (r_v3 && !r_found && sq_dist < r_bestd) begin
                        r_best <= r_p3;
                        r_bestd <= sq_dist;
                        r_found <= (sq_dist == '0);
                    end
                    if (r_state == S_SCAN) begin
                        if (r_cnt == (IdxW+1)'(Entries-2)) begin
                            r_state <= S_DRAIN;
                            r_cnt <= '0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end else begin
                        if (r_cnt == (IdxW+1)'(2)) begin
                            r_cnt <= (IdxW+1)'(1);
                            r_state <= S_FREE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_FREE: begin
                    // r_found decided after drain
                    if (r_found) begin
                        r_res <= merge_res(r_best, OUT_EXACT);
                        r_state <= S_OUT;
                    end else begin
                        r_p1 <= r_cnt[IdxW-1:0];
                        r_v1 <= (r_cnt != '0) && (r_cnt < (IdxW+1)'(Entries));
                        if (r_v1 && r_rdata[31:24] == '0) begin
                            r_res <= merge_res(r_p1, OUT_FREE);
                            r_best <= r_p1;
                            r_state <= S_FREEW;
                        end else if (!r_v1 && r_cnt == (IdxW+1)'(Entries)) begin
                            r_res <= merge_res(r_best, OUT_APPROX);
                            r_state <= S_APRD;
                        end else if (r_cnt != (IdxW+1)'(Entries)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_FREEW: r_state <= S_OUT;
                S_APRD: r_state <= S_APWR;
                S_APWR: r_state <= S_OUT;
                S_OUT: if (o_res.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
